// ----- hw/rtl/epdd_pkg.sv -----
// Shared constants, state encoding and control/status structs for the
// EEG packet deframer. No dependencies; used by all other files.
`timescale 1ns / 1ps

package epdd_pkg;

  // Packet geometry.
  localparam int NUM_CHANNELS  = 7;
  localparam int PAYLOAD_DEPTH = 170;
  localparam int BYTE_W        = 8;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int CH_W          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHAN_FIELD_W  = 3;
  localparam int SAMPLE_W      = 12;

  // Framing bytes and the recognized packet header.
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0] PKT_TAG   = 8'hB0;
  localparam logic [BYTE_W-1:0] TAG_LEN   = BYTE_W'(2 * NUM_CHANNELS);
  localparam logic [BYTE_W-1:0] WANT_LEN  = BYTE_W'(2 * NUM_CHANNELS + 2);

  // Low-byte correction: when the 0x10 bit of the high byte is set,
  // a low byte of 3 is read as 2.
  localparam int                HI_FLAG_BIT = 4;
  localparam logic [BYTE_W-1:0] LO_FIX_FROM = 8'd3;
  localparam logic [BYTE_W-1:0] LO_FIX_TO   = 8'd2;

  localparam logic [CH_W-1:0] CHAN_LAST = CH_W'(NUM_CHANNELS - 1);

  // Result kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Controller states: four framing phases, then the result sequencer.
  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_PAY,
    ST_CHK,
    ST_READ,
    ST_EMIT,
    ST_STATUS
  } epdd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sync_set;
    logic sync_clr;
    logic len_load;
    logic pay_write;
    logic chan_clr;
    logic rd_issue;
    logic emit_sample;
    logic emit_status;
  } epdd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sync;
    logic above_sync;
    logic is_zero;
    logic sync_seen;
    logic pay_done;
    logic chk_ok;
    logic pkt_ok;
    logic chan_last;
    logic out_free;
  } epdd_sts_t;

endpackage

// ----- hw/rtl/epdd_dpath.sv -----
// Datapath of the packet deframer: framing counters, payload memory,
// checksum, sample decode and the output word register. Uses epdd_pkg.
`timescale 1ns / 1ps

module epdd_dpath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_tdata,
  input  epdd_pkg::epdd_cmd_t    cmd,
  output epdd_pkg::epdd_sts_t    sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [23:0]            out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic [epdd_pkg::BYTE_W-1:0] rx_byte;

  // Framing registers.
  logic                        sync_seen_r, sync_seen_nxt;
  logic [epdd_pkg::BYTE_W-1:0] len_r, len_nxt;
  logic [epdd_pkg::BYTE_W-1:0] idx_r, idx_nxt;
  logic [epdd_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic                        tag0_r, tag0_nxt;
  logic                        tag1_r, tag1_nxt;
  logic [epdd_pkg::CH_W-1:0]   chan_r, chan_nxt;

  // Payload memory with two registered read ports.
  logic [epdd_pkg::BYTE_W-1:0] pay_mem [epdd_pkg::PAYLOAD_DEPTH];
  logic                        wr_in_range;
  logic [epdd_pkg::BYTE_W-1:0] hi_addr, lo_addr;
  logic                        hi_oob, lo_oob;
  logic [epdd_pkg::BYTE_W-1:0] hi_q_r, lo_q_r;
  logic                        hi_oob_r, lo_oob_r;

  // Decode and output registers.
  logic [epdd_pkg::BYTE_W-1:0]       hi_val, lo_val, lo_fix;
  logic [epdd_pkg::SAMPLE_W-1:0]     sample_val;
  logic [epdd_pkg::CH_W+2:0]         chan_ext;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_kind_r, out_kind_nxt;
  logic                              out_last_r, out_last_nxt;
  logic [epdd_pkg::CHAN_FIELD_W-1:0] out_chan_r, out_chan_nxt;
  logic [epdd_pkg::SAMPLE_W-1:0]     out_sample_r, out_sample_nxt;
  logic [epdd_pkg::BYTE_W-1:0]       out_len_r, out_len_nxt;

  assign rx_byte = in_tdata;

  // Status toward the controller.
  always_comb begin
    sts.is_sync    = (rx_byte == epdd_pkg::SYNC_BYTE);
    sts.above_sync = (rx_byte > epdd_pkg::SYNC_BYTE);
    sts.is_zero    = (rx_byte == '0);
    sts.sync_seen  = sync_seen_r;
    sts.pay_done   = (({1'b0, idx_r} + 9'd1) >= {1'b0, len_r});
    sts.chk_ok     = (rx_byte == ~sum_r);
    sts.pkt_ok     = (len_r == epdd_pkg::WANT_LEN) && tag0_r && tag1_r;
    sts.chan_last  = (chan_r == epdd_pkg::CHAN_LAST);
    sts.out_free   = !out_valid_r || out_tready;
  end

  // Framing counters, checksum and header flags.
  always_comb begin
    sync_seen_nxt = sync_seen_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    tag0_nxt      = tag0_r;
    tag1_nxt      = tag1_r;
    chan_nxt      = chan_r;
    if (cmd.sync_set) begin
      sync_seen_nxt = 1'b1;
    end else if (cmd.sync_clr) begin
      sync_seen_nxt = 1'b0;
    end
    if (cmd.len_load) begin
      len_nxt = rx_byte;
      idx_nxt = '0;
      sum_nxt = '0;
    end
    if (cmd.pay_write) begin
      sum_nxt = sum_r + rx_byte;
      idx_nxt = idx_r + 8'd1;
      // Header bytes are checked as they arrive.
      if (idx_r == 8'd0) begin
        tag0_nxt = (rx_byte == epdd_pkg::PKT_TAG);
      end
      if (idx_r == 8'd1) begin
        tag1_nxt = (rx_byte == epdd_pkg::TAG_LEN);
      end
    end
    if (cmd.chan_clr) begin
      chan_nxt = '0;
    end else if (cmd.emit_sample) begin
      chan_nxt = chan_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_seen_r <= 1'b0;
      len_r       <= '0;
      idx_r       <= '0;
      sum_r       <= '0;
      tag0_r      <= 1'b0;
      tag1_r      <= 1'b0;
      chan_r      <= '0;
    end else begin
      sync_seen_r <= sync_seen_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      tag0_r      <= tag0_nxt;
      tag1_r      <= tag1_nxt;
      chan_r      <= chan_nxt;
    end
  end

  // Payload memory write; bytes past the end still count in the sum only.
  assign wr_in_range = ({1'b0, idx_r} < 9'(epdd_pkg::PAYLOAD_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.pay_write && wr_in_range) begin
      pay_mem[idx_r[epdd_pkg::ADDR_W-1:0]] <= rx_byte;
    end
  end

  // Read addresses of the current channel's high and low bytes.
  assign hi_addr = 8'd2 + 8'({chan_r, 1'b0});
  assign lo_addr = 8'd3 + 8'({chan_r, 1'b0});
  assign hi_oob  = ({1'b0, hi_addr} >= 9'(epdd_pkg::PAYLOAD_DEPTH));
  assign lo_oob  = ({1'b0, lo_addr} >= 9'(epdd_pkg::PAYLOAD_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      hi_q_r   <= pay_mem[hi_addr[epdd_pkg::ADDR_W-1:0]];
      lo_q_r   <= pay_mem[lo_addr[epdd_pkg::ADDR_W-1:0]];
      hi_oob_r <= hi_oob;
      lo_oob_r <= lo_oob;
    end
  end

  // Sample decode with the low-byte correction.
  always_comb begin
    hi_val     = hi_oob_r ? '0 : hi_q_r;
    lo_val     = lo_oob_r ? '0 : lo_q_r;
    lo_fix     = (hi_val[epdd_pkg::HI_FLAG_BIT] && (lo_val == epdd_pkg::LO_FIX_FROM)) ?
                 epdd_pkg::LO_FIX_TO : lo_val;
    sample_val = {hi_val[3:0], lo_fix};
    chan_ext   = {3'b000, chan_r};
  end

  // Output word register.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    out_chan_nxt   = out_chan_r;
    out_sample_nxt = out_sample_r;
    out_len_nxt    = out_len_r;
    if (cmd.emit_sample) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = epdd_pkg::KIND_SAMPLE;
      out_last_nxt   = (chan_r == epdd_pkg::CHAN_LAST);
      out_chan_nxt   = chan_ext[epdd_pkg::CHAN_FIELD_W-1:0];
      out_sample_nxt = sample_val;
      out_len_nxt    = len_r;
    end else if (cmd.emit_status) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = epdd_pkg::KIND_STATUS;
      out_last_nxt   = 1'b1;
      out_chan_nxt   = '0;
      out_sample_nxt = '0;
      out_len_nxt    = len_r;
    end else if (out_tready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_last_r   <= out_last_nxt;
    out_chan_r   <= out_chan_nxt;
    out_sample_r <= out_sample_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_len_r, out_sample_r, out_chan_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hw/rtl/epdd_ctrl.sv -----
// Controller of the packet deframer: framing phases and the result
// sequencer. Uses epdd_pkg; drives commands into epdd_dpath.
`timescale 1ns / 1ps

module epdd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  epdd_pkg::epdd_sts_t  sts,
  output epdd_pkg::epdd_cmd_t  cmd
);

  epdd_pkg::epdd_state_t state_r, state_nxt;
  logic                  accept;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= epdd_pkg::ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    accept    = 1'b0;
    case (state_r)
      epdd_pkg::ST_HUNT: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        if (accept) begin
          if (sts.is_sync && sts.sync_seen) begin
            cmd.sync_clr = 1'b1;
            state_nxt    = epdd_pkg::ST_LEN;
          end else if (sts.is_sync) begin
            cmd.sync_set = 1'b1;
          end else begin
            cmd.sync_clr = 1'b1;
          end
        end
      end
      epdd_pkg::ST_LEN: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        // Extra sync bytes are skipped.
        if (accept && !sts.is_sync) begin
          if (sts.above_sync) begin
            state_nxt = epdd_pkg::ST_HUNT;
          end else begin
            cmd.len_load = 1'b1;
            state_nxt    = sts.is_zero ? epdd_pkg::ST_CHK : epdd_pkg::ST_PAY;
          end
        end
      end
      epdd_pkg::ST_PAY: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        if (accept) begin
          cmd.pay_write = 1'b1;
          if (sts.pay_done) begin
            state_nxt = epdd_pkg::ST_CHK;
          end
        end
      end
      epdd_pkg::ST_CHK: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        if (accept) begin
          if (!sts.chk_ok) begin
            state_nxt = epdd_pkg::ST_HUNT;
          end else if (sts.pkt_ok) begin
            cmd.chan_clr = 1'b1;
            state_nxt    = epdd_pkg::ST_READ;
          end else begin
            state_nxt = epdd_pkg::ST_STATUS;
          end
        end
      end
      epdd_pkg::ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = epdd_pkg::ST_EMIT;
      end
      epdd_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_sample = 1'b1;
          state_nxt       = sts.chan_last ? epdd_pkg::ST_HUNT : epdd_pkg::ST_READ;
        end
      end
      epdd_pkg::ST_STATUS: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = epdd_pkg::ST_HUNT;
        end
      end
      default: begin
        state_nxt = epdd_pkg::ST_HUNT;
      end
    endcase
  end

endmodule

// ----- hw/rtl/eeg_packet_deframe_decode.sv -----
// Sequential serial byte deframer: one received byte per word, decoded results out.
// Non-result bytes are accepted whenever offered; after a good checksum byte the input is held
// off while the status word or the samples are produced, each sample taking a registered memory
// read (ST_READ) and an output register load (ST_EMIT); output stalls lengthen this sequencing.
// After a good checksum, status goes via ST_STATUS, samples via ST_READ and ST_EMIT, to the output.
// Synchronous active-low reset: hunting for sync, output empty; payload memory is not cleared.
`timescale 1ns / 1ps

module eeg_packet_deframe_decode (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] channel, [14:3] sample, [22:15] packet_length
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast
);

  epdd_pkg::epdd_cmd_t cmd;
  epdd_pkg::epdd_sts_t sts;

  epdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  epdd_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sample || cmd.emit_status) |-> sts.out_free)
    else $error("result loaded while output register is occupied");

  // Input is held off while results are being produced.
  a_no_accept_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sample || cmd.emit_status || cmd.rd_issue) |-> !in_tready)
    else $error("input ready during result sequencing");

  // A status result is a single final word.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_status |=> (out_tvalid && out_tlast && out_tuser))
    else $error("status word not marked last");

  // The last channel's sample closes the run.
  a_sample_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sample && sts.chan_last) |=> (out_tvalid && out_tlast && !out_tuser))
    else $error("final sample not marked last");

endmodule
